@@ hdl/descriptor_checksum_bip380_defines.svh @@
// Assertion macros for the descriptor checksum RTL.
// No dependencies; included by modules that carry assertions.
`ifndef DESCRIPTOR_CHECKSUM_BIP380_DEFINES_SVH
`define DESCRIPTOR_CHECKSUM_BIP380_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dcb_pkg.sv @@
// Shared constants, tables and the GF(32) polymod step for the descriptor checksum.
// No dependencies.
package dcb_pkg;

  localparam int unsigned POLY_W = 40;
  localparam int unsigned SYM_W  = 5;
  localparam int unsigned NUM_CHARS = 8;
  localparam int unsigned ZERO_STEPS = 8;

  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7e;

  localparam logic [POLY_W-1:0] GEN [5] = '{
    40'hf5dee51989, 40'ha9fdca3312, 40'h1bab10e32d,
    40'h3706b1677a, 40'h644d626ffd
  };

  // Position plus one for every printable byte, zero marks unmapped.
  localparam logic [6:0] POS_PLUS_ONE [95] = '{
    7'h5f,7'h3c,7'h5d,7'h5c,7'h1d,7'h1e,7'h33,7'h10,7'h0b,7'h0c,7'h12,7'h34,7'h0f,7'h35,
    7'h36,7'h11,7'h01,7'h02,7'h03,7'h04,7'h05,7'h06,7'h07,7'h08,7'h09,7'h0a,7'h1c,7'h37,
    7'h38,7'h39,7'h3a,7'h3b,7'h1b,7'h53,7'h54,7'h55,7'h56,7'h57,7'h58,7'h59,7'h5a,7'h21,
    7'h22,7'h23,7'h24,7'h25,7'h26,7'h27,7'h28,7'h29,7'h2a,7'h2b,7'h2c,7'h2d,7'h2e,7'h2f,
    7'h30,7'h31,7'h32,7'h0d,7'h5e,7'h0e,7'h3d,7'h3e,7'h5b,7'h13,7'h14,7'h15,7'h16,7'h17,
    7'h18,7'h19,7'h1a,7'h41,7'h42,7'h43,7'h44,7'h45,7'h46,7'h47,7'h48,7'h49,7'h4a,7'h4b,
    7'h4c,7'h4d,7'h4e,7'h4f,7'h50,7'h51,7'h52,7'h1f,7'h3f,7'h20,7'h40
  };

  localparam logic [7:0] CHARSET [32] = '{
    "q","p","z","r","y","9","x","8","g","f","2","t","v","d","w","0",
    "s","3","j","n","5","4","k","h","c","e","6","m","u","a","7","l"
  };

  // Snapshot handed from the absorb stage to the finisher on the last byte.
  typedef struct packed {
    logic              valid;
    logic [POLY_W-1:0] poly;
    logic [SYM_W-1:0]  accum;
    logic              flush;
    logic              err;
  } hand_t;

  function automatic logic [POLY_W-1:0] poly_step(input logic [POLY_W-1:0] r,
                                                  input logic [SYM_W-1:0] s);
    logic [4:0]        top;
    logic [POLY_W-1:0] n;
    top = r[39:35];
    n = {r[34:0], s};
    for (int k = 0; k < 5; k++) begin
      if (top[k]) begin
        n = n ^ GEN[k];
      end
    end
    return n;
  endfunction

endpackage

@@ hdl/dcb_if.sv @@
// Valid/ready channel interfaces for descriptor text in and checksum characters out.
// No dependencies.
interface dcb_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dcb_sum_if;
  logic       valid;
  logic       ready;
  logic [6:0] checksum_char;
  logic       last_of_checksum;
  logic       bad_input;
  modport source (output valid, output checksum_char, output last_of_checksum,
                  output bad_input, input ready);
  modport sink   (input valid, input checksum_char, input last_of_checksum,
                  input bad_input, output ready);
endinterface

@@ hdl/dcb_absorb.sv @@
// Input register and per-byte polymod / class-group update.
// Depends on dcb_pkg and dcb_text_if.
module dcb_absorb (
  input  logic           clk,
  input  logic           rst,
  dcb_text_if.sink       text,
  input  logic           fin_ready,
  output dcb_pkg::hand_t hand
);

  logic                       in_vld;
  logic [7:0]                 in_char;
  logic                       in_last;
  logic [dcb_pkg::POLY_W-1:0] poly;
  logic [4:0]                 accum;
  logic [1:0]                 count;
  logic                       err;

  logic                       consume;
  logic [6:0]                 entry;
  logic [6:0]                 pos;
  logic [6:0]                 idx;
  logic [dcb_pkg::POLY_W-1:0] poly_next;
  logic [4:0]                 accum_next;
  logic [1:0]                 count_next;
  logic                       err_next;
  logic [dcb_pkg::POLY_W-1:0] r1;
  logic [4:0]                 acc_grown;

  // A last byte waits until the finisher is free.
  assign consume    = in_vld && (!in_last || fin_ready);
  assign text.ready = !in_vld || consume;

  always_comb begin
    idx = 7'(in_char - dcb_pkg::PRINT_LO);
    if (in_char >= dcb_pkg::PRINT_LO && in_char <= dcb_pkg::PRINT_HI) begin
      entry = dcb_pkg::POS_PLUS_ONE[idx];
    end else begin
      entry = 7'd0;
    end
    pos       = entry - 7'd1;
    r1        = dcb_pkg::poly_step(poly, pos[4:0]);
    acc_grown = 5'(({2'b00, accum} << 1) + {2'b00, accum} + {5'b00000, pos[6:5]});
    if (entry == 7'd0) begin
      poly_next  = poly;
      accum_next = accum;
      count_next = count;
      err_next   = 1'b1;
    end else if (count == 2'd2) begin
      poly_next  = dcb_pkg::poly_step(r1, acc_grown);
      accum_next = 5'd0;
      count_next = 2'd0;
      err_next   = err;
    end else begin
      poly_next  = r1;
      accum_next = acc_grown;
      count_next = count + 2'd1;
      err_next   = err;
    end
  end

  assign hand.valid = consume && in_last;
  assign hand.poly  = poly_next;
  assign hand.accum = accum_next;
  assign hand.flush = (count_next != 2'd0);
  assign hand.err   = err_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (text.valid && text.ready) begin
      in_vld <= 1'b1;
    end else if (consume) begin
      in_vld <= 1'b0;
    end
    if (text.valid && text.ready) begin
      in_char <= text.char_code;
      in_last <= text.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (consume && in_last)) begin
      poly  <= 40'd1;
      accum <= 5'd0;
      count <= 2'd0;
      err   <= 1'b0;
    end else if (consume) begin
      poly  <= poly_next;
      accum <= accum_next;
      count <= count_next;
      err   <= err_next;
    end
  end

endmodule

@@ hdl/dcb_finish.sv @@
// Finisher: flush step and eight zero steps, up to two per cycle, then send eight characters.
// Depends on dcb_pkg, dcb_sum_if and the assertion macro header.
`include "descriptor_checksum_bip380_defines.svh"

module dcb_finish (
  input  logic           clk,
  input  logic           rst,
  input  dcb_pkg::hand_t hand,
  output logic           fin_ready,
  dcb_sum_if.source      checksum
);

  typedef enum logic [1:0] {IDLE, SQUEEZE, EMIT} state_t;

  state_t                     state;
  logic [dcb_pkg::POLY_W-1:0] poly;
  logic [4:0]                 sym;
  logic [3:0]                 rem;
  logic                       err;
  logic [2:0]                 idx;

  logic [dcb_pkg::POLY_W-1:0] r1;
  logic [dcb_pkg::POLY_W-1:0] r2;
  logic [dcb_pkg::POLY_W-1:0] poly_next;
  logic [3:0]                 rem_next;
  logic                       last_beat;

  assign fin_ready = (state == IDLE);

  always_comb begin
    r1 = dcb_pkg::poly_step(poly, sym);
    r2 = dcb_pkg::poly_step(r1, 5'd0);
    if (rem >= 4'd2) begin
      poly_next = r2;
      rem_next  = rem - 4'd2;
    end else begin
      poly_next = r1;
      rem_next  = rem - 4'd1;
    end
  end

  assign checksum.valid            = (state == EMIT);
  assign checksum.checksum_char    = err ? 7'd0 : 7'(dcb_pkg::CHARSET[poly[39:35]]);
  assign checksum.last_of_checksum = (idx == 3'(dcb_pkg::NUM_CHARS - 1));
  assign checksum.bad_input        = err;

  assign last_beat = checksum.valid && checksum.ready && checksum.last_of_checksum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      idx   <= 3'd0;
      rem   <= 4'd0;
    end else begin
      case (state)
        IDLE: begin
          if (hand.valid) begin
            poly  <= hand.poly;
            sym   <= hand.flush ? hand.accum : 5'd0;
            rem   <= hand.flush ? 4'(dcb_pkg::ZERO_STEPS + 1) : 4'(dcb_pkg::ZERO_STEPS);
            err   <= hand.err;
            state <= SQUEEZE;
          end
        end
        SQUEEZE: begin
          sym <= 5'd0;
          rem <= rem_next;
          if (rem_next == 4'd0) begin
            poly  <= poly_next ^ 40'd1;
            idx   <= 3'd0;
            state <= EMIT;
          end else begin
            poly <= poly_next;
          end
        end
        EMIT: begin
          if (checksum.ready) begin
            poly <= poly << 5;
            idx  <= idx + 3'd1;
            if (idx == 3'(dcb_pkg::NUM_CHARS - 1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `DCB_ASSERT_NOW(a_hand_when_idle, hand.valid, state == IDLE, "handoff while finisher busy")
  `DCB_ASSERT_NOW(a_squeeze_rem, state == SQUEEZE, rem != 4'd0, "squeeze with no steps left")
  `DCB_ASSERT_NEXT(a_final_beat, last_beat, state == IDLE, "finisher did not return to idle")

endmodule

@@ hdl/descriptor_checksum_bip380.sv @@
// Descriptor checksum: one body byte per cycle in, eight checksum characters out per body.
// Last byte: input register, snapshot to the finisher, squeeze steps (one more with a flush), EMIT.
// Throughput: one byte per cycle; a last byte waits while the previous checksum is in flight.
// Finisher runs up to two polymod steps per cycle, then sends one character per beat.
// Reset: synchronous rst clears handshakes, polymod to one, class group and error flag to zero.
module descriptor_checksum_bip380 (
  input  logic      clk,
  input  logic      rst,
  dcb_text_if.sink  text,
  dcb_sum_if.source checksum
);

  // Snapshot of the finished body state, moved in the cycle the last byte retires.
  dcb_pkg::hand_t hand;
  // Finisher free to take a new snapshot.
  logic           fin_ready;

  // Absorb: register each beat, map it, advance polymod and class group.
  dcb_absorb u_absorb (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .fin_ready (fin_ready),
    .hand      (hand)
  );

  // Finish: flush, apply zero symbols, fold in the constant, send characters.
  dcb_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .hand      (hand),
    .fin_ready (fin_ready),
    .checksum  (checksum)
  );

endmodule

@@ tb/descriptor_sum_checker.sv @@
// Checker for the descriptor checksum block: watches both channels, predicts the checksum.
// Depends on the dcb_text_if and dcb_sum_if interfaces only.
module descriptor_sum_checker (
  input  logic  clk,
  input  logic  rst,
  dcb_text_if   text,
  dcb_sum_if    checksum,
  output int    mismatches,
  output int    sums_pending,
  output int    bodies_closed,
  output int    flagged_bodies,
  output int    chars_checked
);

  localparam logic [39:0] GF_GEN [5] = '{
    40'hf5dee51989, 40'ha9fdca3312, 40'h1bab10e32d,
    40'h3706b1677a, 40'h644d626ffd
  };

  // Position plus one for bytes 0x20..0x7e.
  localparam logic [6:0] TEXT_POS [95] = '{
    7'h5f,7'h3c,7'h5d,7'h5c,7'h1d,7'h1e,7'h33,7'h10,7'h0b,7'h0c,7'h12,7'h34,7'h0f,7'h35,
    7'h36,7'h11,7'h01,7'h02,7'h03,7'h04,7'h05,7'h06,7'h07,7'h08,7'h09,7'h0a,7'h1c,7'h37,
    7'h38,7'h39,7'h3a,7'h3b,7'h1b,7'h53,7'h54,7'h55,7'h56,7'h57,7'h58,7'h59,7'h5a,7'h21,
    7'h22,7'h23,7'h24,7'h25,7'h26,7'h27,7'h28,7'h29,7'h2a,7'h2b,7'h2c,7'h2d,7'h2e,7'h2f,
    7'h30,7'h31,7'h32,7'h0d,7'h5e,7'h0e,7'h3d,7'h3e,7'h5b,7'h13,7'h14,7'h15,7'h16,7'h17,
    7'h18,7'h19,7'h1a,7'h41,7'h42,7'h43,7'h44,7'h45,7'h46,7'h47,7'h48,7'h49,7'h4a,7'h4b,
    7'h4c,7'h4d,7'h4e,7'h4f,7'h50,7'h51,7'h52,7'h1f,7'h3f,7'h20,7'h40
  };

  localparam logic [8*32-1:0] SUM_ALPHABET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef struct packed {
    logic [6:0] sym_char;
    logic       final_beat;
    logic       flagged;
  } sum_beat_t;

  sum_beat_t   expected_sum_chars [$];
  logic [39:0] poly_acc;
  logic [4:0]  grp_digits;
  int          grp_len;
  logic        text_err;
  int          mismatch_cnt;
  int          body_cnt;
  int          bad_cnt;
  int          char_cnt;
  int          queued;

  assign mismatches     = mismatch_cnt;
  assign sums_pending   = queued;
  assign bodies_closed  = body_cnt;
  assign flagged_bodies = bad_cnt;
  assign chars_checked  = char_cnt;

  function automatic logic [39:0] gf_shift(input logic [39:0] acc, input logic [4:0] sym);
    logic [39:0] nxt;
    nxt = {acc[34:0], sym};
    for (int k = 0; k < 5; k++) begin
      if (acc[35+k]) begin
        nxt = nxt ^ GF_GEN[k];
      end
    end
    return nxt;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $time);
    mismatch_cnt++;
  endtask

  // Fold one body byte into the running checksum; on the last byte queue the eight chars.
  task automatic absorb_text_byte(input logic [7:0] code, input logic closing);
    logic [6:0]  entry;
    logic [6:0]  pos;
    logic [39:0] acc;
    logic [4:0]  sym;
    sum_beat_t   beat;
    entry = '0;
    if (code >= 8'h20 && code <= 8'h7e) begin
      entry = TEXT_POS[code - 8'h20];
    end
    if (entry == '0) begin
      text_err = 1'b1;
    end else begin
      pos = entry - 7'd1;
      poly_acc = gf_shift(poly_acc, pos[4:0]);
      grp_digits = 5'(grp_digits * 3 + pos[6:5]);
      grp_len++;
      if (grp_len == 3) begin
        poly_acc = gf_shift(poly_acc, grp_digits);
        grp_digits = '0;
        grp_len = 0;
      end
    end
    if (closing) begin
      acc = poly_acc;
      if (grp_len > 0) begin
        acc = gf_shift(acc, grp_digits);
      end
      for (int i = 0; i < 8; i++) begin
        acc = gf_shift(acc, 5'd0);
      end
      acc = acc ^ 40'd1;
      for (int i = 0; i < 8; i++) begin
        sym = acc[5*(7-i) +: 5];
        beat.sym_char = text_err ? 7'd0 : SUM_ALPHABET[8*(31-sym) +: 7];
        beat.final_beat = (i == 7);
        beat.flagged = text_err;
        expected_sum_chars.push_back(beat);
      end
      body_cnt++;
      if (text_err) begin
        bad_cnt++;
      end
      poly_acc = 40'd1;
      grp_digits = '0;
      grp_len = 0;
      text_err = 1'b0;
    end
  endtask

  initial begin
    mismatch_cnt = 0;
    body_cnt = 0;
    bad_cnt = 0;
    char_cnt = 0;
    queued = 0;
  end

  always @(posedge clk) begin
    sum_beat_t want;
    if (rst) begin
      poly_acc = 40'd1;
      grp_digits = '0;
      grp_len = 0;
      text_err = 1'b0;
      expected_sum_chars.delete();
    end else begin
      if (text.valid && text.ready) begin
        absorb_text_byte(text.char_code, text.last_char);
      end
      if (checksum.valid && checksum.ready) begin
        if (expected_sum_chars.size() == 0) begin
          report_mismatch("checksum beat with nothing expected",
                          int'(checksum.checksum_char), 0);
        end else begin
          want = expected_sum_chars.pop_front();
          char_cnt++;
          if (checksum.checksum_char !== want.sym_char) begin
            report_mismatch("checksum_char", int'(checksum.checksum_char),
                            int'(want.sym_char));
          end
          if (checksum.last_of_checksum !== want.final_beat) begin
            report_mismatch("last_of_checksum", int'(checksum.last_of_checksum),
                            int'(want.final_beat));
          end
          if (checksum.bad_input !== want.flagged) begin
            report_mismatch("bad_input", int'(checksum.bad_input), int'(want.flagged));
          end
        end
      end
    end
    queued <= expected_sum_chars.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the descriptor checksum testbench: clock, reset, text stimulus, receiver stalls.
// Depends on dcb_if.sv, the descriptor_checksum_bip380 RTL and descriptor_sum_checker.sv.
module tb_top;

  logic clk;
  logic rst;

  int mismatches;
  int sums_pending;
  int bodies_closed;
  int flagged_bodies;
  int chars_checked;

  // Sender burst state: beats left in the current burst.
  int burst_left;
  int bytes_sent;

  dcb_text_if text_ch ();
  dcb_sum_if  sum_ch ();

  descriptor_checksum_bip380 dut (
    .clk      (clk),
    .rst      (rst),
    .text     (text_ch),
    .checksum (sum_ch)
  );

  descriptor_sum_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .text           (text_ch),
    .checksum       (sum_ch),
    .mismatches     (mismatches),
    .sums_pending   (sums_pending),
    .bodies_closed  (bodies_closed),
    .flagged_bodies (flagged_bodies),
    .chars_checked  (chars_checked)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: stall on a pattern that switches at random among modes. Modes are
  // always ready, coin flip, one beat in four, and long alternating runs.
  initial begin
    int cyc;
    int stall_mode;
    int run_left;
    cyc = 0;
    stall_mode = 0;
    run_left = 0;
    sum_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 97 == 0) begin
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0: begin
          sum_ch.ready = 1'b1;
        end
        1: begin
          sum_ch.ready = 1'($urandom_range(0, 1));
        end
        2: begin
          sum_ch.ready = (cyc % 4 == 0);
        end
        default: begin
          if (run_left == 0) begin
            sum_ch.ready = !sum_ch.ready;
            run_left = $urandom_range(1, 12);
          end else begin
            run_left--;
          end
        end
      endcase
    end
  end

  // Send one text beat. Between bursts, drop valid for a random gap; then
  // hold the beat until the block takes it.
  task automatic send_byte(input logic [7:0] code, input logic closing);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        text_ch.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    text_ch.valid = 1'b1;
    text_ch.char_code = code;
    text_ch.last_char = closing;
    do @(posedge clk); while (!text_ch.ready);
    bytes_sent++;
  endtask

  // Mostly printable text; a few bytes outside 0x20..0x7e, from either side.
  function automatic logic [7:0] pick_body_byte();
    if ($urandom_range(0, 99) < 4) begin
      if ($urandom_range(0, 1) == 1) begin
        return 8'($urandom_range(8'h00, 8'h1f));
      end
      return 8'($urandom_range(8'h7f, 8'hff));
    end
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  // Send one body of random content; length mostly short, now and then long.
  task automatic send_random_body();
    int len;
    int roll;
    int bad_at;
    logic [7:0] code;
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      len = $urandom_range(1, 10);
    end else if (roll < 95) begin
      len = $urandom_range(11, 30);
    end else begin
      len = $urandom_range(31, 60);
    end
    // Force one unprintable byte into a few bodies at a random spot.
    bad_at = ($urandom_range(0, 99) < 5) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      code = (i == bad_at) ? 8'($urandom_range(8'h80, 8'hff)) : pick_body_byte();
      send_byte(code, i == len - 1);
    end
  endtask

  initial begin
    burst_left = 0;
    bytes_sent = 0;
    rst = 1'b1;
    text_ch.valid = 1'b0;
    text_ch.char_code = 8'h00;
    text_ch.last_char = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // One-byte body: a class group of a single digit is flushed at the end.
    send_byte("a", 1'b1);
    // Two bytes: flush of a two-digit group.
    send_byte("w", 1'b0);
    send_byte("(", 1'b1);
    // Three bytes: the group folds in line, nothing left to flush.
    send_byte("p", 1'b0);
    send_byte("k", 1'b0);
    send_byte("h", 1'b1);
    // Edges of the printable range and all three class digits.
    send_byte(8'h20, 1'b0);
    send_byte(8'h7e, 1'b0);
    send_byte("A", 1'b0);
    send_byte("0", 1'b1);
    // Unprintable bytes just outside both edges, mid body.
    send_byte("x", 1'b0);
    send_byte(8'h1f, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte("y", 1'b1);
    // Body of a single unprintable byte.
    send_byte(8'h00, 1'b1);
    // Unprintable byte that is itself the last one.
    send_byte("s", 1'b0);
    send_byte(8'hff, 1'b1);
    // Clean body right after bad ones: the error flag must have cleared.
    send_byte("r", 1'b0);
    send_byte("a", 1'b0);
    send_byte("w", 1'b0);
    send_byte("(", 1'b1);

    // Random bodies until the byte budget is spent; every body ends on a last byte.
    while (bytes_sent < 320) begin
      send_random_body();
    end

    @(negedge clk);
    text_ch.valid = 1'b0;
    text_ch.last_char = 1'b0;

    // Drain every queued character, then idle past the block's latency to catch strays.
    while (sums_pending != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d text bytes in %0d bodies, %0d with unprintable bytes;",
             bytes_sent, bodies_closed, flagged_bodies);
    $display("checked %0d checksum characters under random sender gaps and receiver stalls.",
             chars_checked);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/dcb_pkg.sv
hdl/dcb_if.sv
hdl/dcb_absorb.sv
hdl/dcb_finish.sv
hdl/descriptor_checksum_bip380.sv
tb/descriptor_sum_checker.sv
tb/tb_top.sv
